[hdl/m31_tpe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m31_tpe_pkg
// Shared types, codes and modular helpers for the Mersenne-31 ternary pair
// expander.
// ----------------------------------------------------------------------------
package m31_tpe_pkg;

  localparam logic [30:0] M31_P   = 31'h7FFFFFFF;
  localparam logic [30:0] EXP_INV = 31'h7FFFFFFD;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COEFF = 2'd1;
  localparam logic [1:0] ST_NO_COEFF  = 2'd2;

  localparam logic [1:0] K_LOAD   = 2'd0;
  localparam logic [1:0] K_EXPAND = 2'd1;
  localparam logic [1:0] K_BAD    = 2'd2;
  localparam logic [1:0] K_NOLOAD = 2'd3;

  localparam logic ACT_LOAD = 1'b0;

  typedef struct packed {
    logic        action;
    logic [29:0] coefficient;
    logic [30:0] pair_x;
    logic [30:0] pair_y;
  } m31_in_t;

  typedef struct packed {
    logic [30:0] out_x;
    logic [30:0] out_y;
    logic        last;
    logic [1:0]  status;
  } m31_out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [29:0] coeff;
    logic [30:0] x;
    logic [30:0] y;
  } m31_entry_t;

  function automatic logic [30:0] m31_reduce(input logic [61:0] p);
    logic [31:0] s;
    logic [30:0] t;
    s = {1'b0, p[61:31]} + {1'b0, p[30:0]};
    t = s[30:0] + {30'd0, s[31]};
    return (t == M31_P) ? 31'd0 : t;
  endfunction

  function automatic logic [30:0] m31_add(input logic [30:0] u, input logic [30:0] v);
    logic [31:0] s;
    s = {1'b0, u} + {1'b0, v};
    return (s >= {1'b0, M31_P}) ? 31'(s - {1'b0, M31_P}) : s[30:0];
  endfunction

  function automatic logic [30:0] m31_sub(input logic [30:0] u, input logic [30:0] v);
    logic [31:0] s;
    s = {1'b0, u} + {1'b0, M31_P} - {1'b0, v};
    return (s >= {1'b0, M31_P}) ? 31'(s - {1'b0, M31_P}) : s[30:0];
  endfunction

endpackage

[hdl/m31_tpe_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m31_tpe_front
// Accepts input items, reduces the pair into range and classifies each item
// as a load, an expand or one of the two error cases.
// ----------------------------------------------------------------------------
module m31_tpe_front
  import m31_tpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  m31_in_t    in_data,
  input  logic       q_full,
  output logic       q_push,
  output m31_entry_t q_entry
);

  logic loaded_r;
  logic loaded_nxt;
  logic good_load;

  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;
  assign good_load = (in_data.action == ACT_LOAD) && (in_data.coefficient >= 30'd2);

  always_comb begin
    q_entry.coeff = in_data.coefficient;
    q_entry.x     = (in_data.pair_x == M31_P) ? 31'd0 : in_data.pair_x;
    q_entry.y     = (in_data.pair_y == M31_P) ? 31'd0 : in_data.pair_y;
    if (in_data.action == ACT_LOAD) begin
      q_entry.kind = good_load ? K_LOAD : K_BAD;
    end else begin
      q_entry.kind = loaded_r ? K_EXPAND : K_NOLOAD;
    end
  end

  assign loaded_nxt = loaded_r || (q_push && good_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
    end
  end

endmodule

[hdl/m31_tpe_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m31_tpe_queue
// Short first-in first-out queue of classified items between the front and
// the back.
// ----------------------------------------------------------------------------
module m31_tpe_queue
  import m31_tpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  m31_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output m31_entry_t head
);

  m31_entry_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_nxt;
  logic [Q_CW-1:0]  count_r;
  logic [Q_CW-1:0]  count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == Q_CW'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/m31_tpe_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m31_tpe_back
// Executes queued items with one shared modular multiplier: square-and-multiply
// sequencing for loads, three child transfers for expands, one for errors.
// ----------------------------------------------------------------------------
module m31_tpe_back
  import m31_tpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  m31_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output m31_out_t   out_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_SQ_M = 4'd2;
  localparam logic [3:0] S_SQ_R = 4'd3;
  localparam logic [3:0] S_ML_M = 4'd4;
  localparam logic [3:0] S_ML_R = 4'd5;
  localparam logic [3:0] S_R_M  = 4'd6;
  localparam logic [3:0] S_R_R  = 4'd7;
  localparam logic [3:0] S_LD   = 4'd8;
  localparam logic [3:0] S_X0   = 4'd9;
  localparam logic [3:0] S_X1   = 4'd10;
  localparam logic [3:0] S_X2   = 4'd11;

  logic [3:0]  state_r,     state_nxt;
  logic        out_valid_r, out_valid_nxt;
  m31_out_t    out_data_r,  out_data_nxt;
  logic [29:0] a_r,         a_nxt;
  logic [30:0] x_r,         x_nxt;
  logic [30:0] y_r,         y_nxt;
  logic [1:0]  err_r,       err_nxt;
  logic [30:0] acc_r,       acc_nxt;
  logic [30:0] base_r,      base_nxt;
  logic [4:0]  cnt_r,       cnt_nxt;
  logic        pass_r,      pass_nxt;
  logic [30:0] coeff_a_r,   coeff_a_nxt;
  logic [30:0] ratio_r,     ratio_nxt;
  logic [30:0] rinv_r,      rinv_nxt;
  logic [61:0] prod_r;
  logic [30:0] op_a;
  logic [30:0] op_b;
  logic [30:0] red;
  logic [30:0] num;
  logic        out_free;
  logic        emit;
  m31_out_t    emit_data;
  logic [3:0]  after_bit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign red       = m31_reduce(prod_r);
  assign num       = 31'd0 - {1'b0, a_r};
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    case (state_r)
      S_SQ_M:  begin op_a = acc_r; op_b = acc_r;  end
      S_ML_M:  begin op_a = acc_r; op_b = base_r; end
      S_R_M:   begin op_a = num;   op_b = acc_r;  end
      S_X0:    begin op_a = y_r;   op_b = ratio_r; end
      S_X1:    begin op_a = y_r;   op_b = out_free ? rinv_r : ratio_r; end
      S_X2:    begin op_a = y_r;   op_b = rinv_r; end
      default: begin op_a = acc_r; op_b = acc_r;  end
    endcase
  end

  always_comb begin
    if (cnt_r == 5'd0) begin
      after_bit = pass_r ? S_LD : S_R_M;
    end else begin
      after_bit = S_SQ_M;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    a_nxt       = a_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    err_nxt     = err_r;
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    cnt_nxt     = cnt_r;
    pass_nxt    = pass_r;
    coeff_a_nxt = coeff_a_r;
    ratio_nxt   = ratio_r;
    rinv_nxt    = rinv_r;
    emit        = 1'b0;
    emit_data   = '0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          a_nxt    = q_head.coeff;
          x_nxt    = q_head.x;
          y_nxt    = q_head.y;
          acc_nxt  = 31'd1;
          base_nxt = {1'b0, q_head.coeff} + 31'd1;
          cnt_nxt  = 5'd30;
          pass_nxt = 1'b0;
          case (q_head.kind)
            K_LOAD:   state_nxt = S_SQ_M;
            K_EXPAND: state_nxt = S_X0;
            K_BAD: begin
              err_nxt   = ST_BAD_COEFF;
              state_nxt = S_ERR;
            end
            default: begin
              err_nxt   = ST_NO_COEFF;
              state_nxt = S_ERR;
            end
          endcase
        end
      end
      S_ERR: begin
        emit             = out_free;
        emit_data.last   = 1'b1;
        emit_data.status = err_r;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SQ_M: state_nxt = S_SQ_R;
      S_SQ_R: begin
        acc_nxt = red;
        if (EXP_INV[cnt_r]) begin
          state_nxt = S_ML_M;
        end else begin
          state_nxt = after_bit;
          cnt_nxt   = cnt_r - 5'd1;
        end
      end
      S_ML_M: state_nxt = S_ML_R;
      S_ML_R: begin
        acc_nxt   = red;
        state_nxt = after_bit;
        cnt_nxt   = cnt_r - 5'd1;
      end
      S_R_M: state_nxt = S_R_R;
      S_R_R: begin
        base_nxt  = red;
        acc_nxt   = 31'd1;
        cnt_nxt   = 5'd30;
        pass_nxt  = 1'b1;
        state_nxt = S_SQ_M;
      end
      S_LD: begin
        emit           = out_free;
        emit_data.out_x = base_r;
        emit_data.out_y = acc_r;
        emit_data.last  = 1'b1;
        emit_data.status = ST_OK;
        if (out_free) begin
          coeff_a_nxt = {1'b0, a_r};
          ratio_nxt   = base_r;
          rinv_nxt    = acc_r;
          state_nxt   = S_IDLE;
        end
      end
      S_X0: begin
        emit            = out_free;
        emit_data.out_x = x_r;
        emit_data.out_y = y_r;
        if (out_free) begin
          state_nxt = S_X1;
        end
      end
      S_X1: begin
        emit            = out_free;
        emit_data.out_x = m31_add(x_r, coeff_a_r);
        emit_data.out_y = red;
        if (out_free) begin
          state_nxt = S_X2;
        end
      end
      S_X2: begin
        emit            = out_free;
        emit_data.out_x = m31_sub(x_r, coeff_a_r);
        emit_data.out_y = red;
        emit_data.last  = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      coeff_a_r   <= '0;
      ratio_r     <= '0;
      rinv_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      coeff_a_r   <= coeff_a_nxt;
      ratio_r     <= ratio_nxt;
      rinv_r      <= rinv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    a_r        <= a_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    err_r      <= err_nxt;
    acc_r      <= acc_nxt;
    base_r     <= base_nxt;
    cnt_r      <= cnt_nxt;
    pass_r     <= pass_nxt;
    prod_r     <= 62'(op_a) * 62'(op_b);
  end

endmodule

[hdl/m31_ternary_pair_expand.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m31_ternary_pair_expand
// Expand: three child transfers per item, offered one after another from the output register.
// Load: two 31-bit Fermat exponentiations on one multiplier, then one result transfer.
// Errors: one transfer per item, marked last with an error status.
// A queue of four items lets the front accept while the back is busy.
// Reset empties the queue and forgets the loaded coefficient.
// ----------------------------------------------------------------------------
module m31_ternary_pair_expand
  import m31_tpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  m31_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output m31_out_t out_data
);

  logic       q_full;
  logic       q_push;
  m31_entry_t q_entry;
  logic       q_pop;
  logic       q_empty;
  m31_entry_t q_head;

  m31_tpe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  m31_tpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  m31_tpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Mersenne-31 ternary pair expander. A queue of
// load and expand transfers feeds a bursty driver, a monitor predicts the
// ratio and inverse ratio of a load, three children of an expand or one
// error result for each accepted transfer, and each result is compared field
// by field with the prediction as the result side stalls on patterns of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import m31_tpe_pkg::*;

  localparam logic ACT_EXPAND = 1'b1;
  localparam logic [29:0] COEFF_MAX = 30'h3FFFFFFF;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD = 400;

  localparam logic [1:0] RX_FREE   = 2'd0;
  localparam logic [1:0] RX_COIN   = 2'd1;
  localparam logic [1:0] RX_EVERY3 = 2'd2;
  localparam logic [1:0] RX_HEAVY  = 2'd3;

  typedef struct {
    logic    sync;
    m31_in_t item;
  } stim_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  m31_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  m31_out_t out_data;

  stim_t    stim_q[$];
  m31_out_t child_q[$];
  stim_t    next_stim;

  logic [30:0] lvl_a;
  logic [30:0] lvl_r;
  logic [30:0] lvl_s;
  logic        lvl_loaded;

  logic in_taken;
  int   burst_left;
  int   gap_left;
  int   hold_left;
  logic hold1_done;
  logic hold2_done;
  logic [1:0] rx_mode;
  logic [5:0] rx_tick;

  int n_accepted;
  int n_loads;
  int n_bad;
  int n_expands;
  int n_noload;
  int n_results;
  int n_errors;
  int n_holds;

  m31_ternary_pair_expand u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [30:0] m31_mulmod(input logic [30:0] u, input logic [30:0] v);
    longint unsigned prod;
    prod = longint'(u) * longint'(v);
    return 31'(prod % 64'd2147483647);
  endfunction

  function automatic logic [30:0] m31_powmod(input logic [30:0] base, input logic [30:0] ex);
    logic [30:0] acc;
    logic [30:0] b;
    logic [30:0] e;
    acc = 31'd1;
    b = (base == M31_P) ? 31'd0 : base;
    e = ex;
    while (e != 31'd0) begin
      if (e[0]) acc = m31_mulmod(acc, b);
      b = m31_mulmod(b, b);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic m31_out_t child(input logic [30:0] x, input logic [30:0] y,
                                     input logic lst, input logic [1:0] st);
    m31_out_t o;
    o.out_x = x;
    o.out_y = y;
    o.last = lst;
    o.status = st;
    return o;
  endfunction

  task automatic predict_children(input m31_in_t it);
    logic [30:0] x;
    logic [30:0] y;
    logic [30:0] num;
    logic [30:0] den;
    logic [30:0] r;
    logic [30:0] s;
    longint unsigned t;
    x = (it.pair_x == M31_P) ? 31'd0 : it.pair_x;
    y = (it.pair_y == M31_P) ? 31'd0 : it.pair_y;
    if (it.action == ACT_LOAD) begin
      if (it.coefficient < 30'd2) begin
        child_q.insert(child_q.size(), child(31'd0, 31'd0, 1'b1, ST_BAD_COEFF));
        n_bad++;
      end else begin
        num = 31'(64'd2147483648 - longint'(it.coefficient));
        den = m31_powmod(31'(it.coefficient) + 31'd1, EXP_INV);
        r = m31_mulmod(num, den);
        s = m31_powmod(r, EXP_INV);
        lvl_a = 31'(it.coefficient);
        lvl_r = r;
        lvl_s = s;
        lvl_loaded = 1'b1;
        child_q.insert(child_q.size(), child(r, s, 1'b1, ST_OK));
        n_loads++;
      end
    end else if (!lvl_loaded) begin
      child_q.insert(child_q.size(), child(31'd0, 31'd0, 1'b1, ST_NO_COEFF));
      n_noload++;
    end else begin
      child_q.insert(child_q.size(), child(x, y, 1'b0, ST_OK));
      t = (longint'(x) + longint'(lvl_a)) % 64'd2147483647;
      child_q.insert(child_q.size(), child(31'(t), m31_mulmod(y, lvl_r), 1'b0, ST_OK));
      t = (longint'(x) + 64'd2147483647 - longint'(lvl_a)) % 64'd2147483647;
      child_q.insert(child_q.size(), child(31'(t), m31_mulmod(y, lvl_s), 1'b1, ST_OK));
      n_expands++;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH result %0d %s: got %h, expected %h", n_results, what, got, want);
    n_errors++;
  endtask

  task automatic queue_item(input logic act, input logic [29:0] c, input logic [30:0] x,
                            input logic [30:0] y, input logic sync);
    stim_t e;
    e.sync = sync;
    e.item.action = act;
    e.item.coefficient = c;
    e.item.pair_x = x;
    e.item.pair_y = y;
    stim_q.insert(stim_q.size(), e);
  endtask

  function automatic logic [30:0] rand_residue();
    case ($urandom_range(0, 7))
      0: return 31'd0;
      1: return M31_P - 31'd1;
      2: return M31_P;
      3: return 31'd1;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [29:0] rand_coeff();
    logic [29:0] c;
    case ($urandom_range(0, 5))
      0: c = 30'd2;
      1: c = COEFF_MAX;
      default: c = 30'($urandom);
    endcase
    return (c < 30'd2) ? 30'd2 : c;
  endfunction

  // Driver: bursts of transfers with random gaps, no gaps while the result side
  // is held off, and a pause before any item marked for sync.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (gap_left != 0 && hold_left == 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (stim_q.size() != 0 && !(stim_q[0].sync && child_q.size() != 0)) begin
      next_stim = stim_q.pop_front();
      in_valid <= 1'b1;
      in_data <= next_stim.item;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 :
                    ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
                    $urandom_range(1, 5);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side: stall pattern is redrawn whenever rx_tick wraps, with two long holds.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 6'd1;
      if (rx_tick == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (n_accepted >= 90 && !hold1_done) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD;
        hold1_done <= 1'b1;
        n_holds++;
      end else if (n_accepted >= 190 && !hold2_done) begin
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD;
        hold2_done <= 1'b1;
        n_holds++;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_COIN:   out_stall <= 1'($urandom_range(0, 1));
          RX_EVERY3: out_stall <= (rx_tick % 3 == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: predict on input transfers, check on result transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_children(in_data);
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (child_q.size() == 0) begin
          report_mismatch("unexpected transfer",
                          longint'({out_data.out_x, out_data.out_y}), 64'd0);
        end else begin
          m31_out_t want;
          want = child_q.pop_front();
          if (out_data.out_x !== want.out_x)
            report_mismatch("out_x", longint'(out_data.out_x), longint'(want.out_x));
          if (out_data.out_y !== want.out_y)
            report_mismatch("out_y", longint'(out_data.out_y), longint'(want.out_y));
          if (out_data.last !== want.last)
            report_mismatch("last", longint'(out_data.last), longint'(want.last));
          if (out_data.status !== want.status)
            report_mismatch("status", longint'(out_data.status), longint'(want.status));
        end
        n_results++;
      end
    end
  end

  initial begin
    int r;
    int drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    in_taken = 1'b0;
    burst_left = 0;
    gap_left = 0;
    hold_left = 0;
    hold1_done = 1'b0;
    hold2_done = 1'b0;
    rx_mode = RX_FREE;
    rx_tick = '0;
    lvl_a = '0;
    lvl_r = '0;
    lvl_s = '0;
    lvl_loaded = 1'b0;
    n_accepted = 0;
    n_loads = 0;
    n_bad = 0;
    n_expands = 0;
    n_noload = 0;
    n_results = 0;
    n_errors = 0;
    n_holds = 0;

    // Expands before any load, rejected loads that must not load anything,
    // both coefficient extremes, pair extremes and components equal to P.
    queue_item(ACT_EXPAND, 30'd5, M31_P - 31'd1, 31'd1, 1'b0);
    queue_item(ACT_LOAD, 30'd0, 31'd0, 31'd0, 1'b0);
    queue_item(ACT_LOAD, 30'd1, M31_P, M31_P, 1'b0);
    queue_item(ACT_EXPAND, COEFF_MAX, 31'd3, 31'd4, 1'b0);
    queue_item(ACT_LOAD, 30'd2, 31'd0, 31'd0, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, 31'd0, 31'd0, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, M31_P - 31'd1, M31_P - 31'd1, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, M31_P, M31_P, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, 31'd1, 31'd1, 1'b0);
    queue_item(ACT_LOAD, COEFF_MAX, M31_P, M31_P, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, 31'd0, 31'd1, 1'b0);
    queue_item(ACT_EXPAND, COEFF_MAX, M31_P - 31'd1, M31_P - 31'd1, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, 31'd1073741823, 31'd2, 1'b0);
    queue_item(ACT_LOAD, 30'd0, 31'd7, 31'd9, 1'b0);
    queue_item(ACT_EXPAND, 30'd0, 31'h2AAAAAAA, 31'h55555555, 1'b0);
    queue_item(ACT_LOAD, 30'd3, 31'd0, 31'd0, 1'b0);
    queue_item(ACT_EXPAND, COEFF_MAX, M31_P, M31_P - 31'd1, 1'b0);
    queue_item(ACT_LOAD, 30'h15555555, 31'd0, 31'd0, 1'b0);
    queue_item(ACT_EXPAND, 30'h2AAAAAAA, 31'h7FFFFFFE, 31'h7FFFFFFE, 1'b0);

    // Random part: mostly expands against the current level, with occasional
    // new levels, rejected loads, and three points where the sender drains.
    for (int i = 0; i < 250; i++) begin
      r = $urandom_range(0, 99);
      if (r < 7)
        queue_item(ACT_LOAD, rand_coeff(), 31'($urandom), 31'($urandom),
                   i == 0 || i == 130 || i == 230);
      else if (r < 11)
        queue_item(ACT_LOAD, 30'($urandom_range(0, 1)), rand_residue(), rand_residue(),
                   i == 0 || i == 130 || i == 230);
      else
        queue_item(ACT_EXPAND, 30'($urandom), rand_residue(), rand_residue(),
                   i == 0 || i == 130 || i == 230);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid || child_q.size() != 0) @(posedge clk);
    for (drain = 0; drain < 60; drain++) @(posedge clk);

    $display("Covered %0d input transfers: %0d loads, %0d rejected coefficients, %0d expands,",
             n_accepted, n_loads, n_bad, n_expands);
    $display("%0d expands with no coefficient, %0d result transfers, %0d long holds.",
             n_noload, n_results, n_holds);
    if (n_errors == 0 && child_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(12.0 * LIMIT_CYCLES);
    $display("tb_top failed");
    $finish;
  end

endmodule
